// File: src/jsu_pkg.sv
package jsu_pkg;

	// Input item: one raw byte of the text stream
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_data;
	} item_t;

	// Result item: one decoded byte, a close mark or an error mark
	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic       last_of_run;
	} result_t;

	// Result kinds
	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_ERR   = 2'd2;

	// Decoder phase
	typedef enum logic [1:0] {
		PH_WAIT = 2'd0,
		PH_STR  = 2'd1,
		PH_ESC  = 2'd2,
		PH_HEX  = 2'd3
	} phase_t;

	// All results caused by one input byte: up to three bytes of one kind
	typedef struct packed {
		logic [1:0]      count;
		logic [1:0]      kind;
		logic [2:0][7:0] data;
	} run_t;

	// Queue between classifier and emitter
	localparam int QDepth = 4;
	localparam int QAw    = 2;

	typedef struct packed {
		logic valid;
		run_t run;
	} head_t;

endpackage

// File: src/jsu_front.sv
module jsu_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  jsu_pkg::item_t item,
	input  logic           queue_full,
	output logic           push,
	output jsu_pkg::run_t  push_run
);

	localparam logic [7:0] CHR_QUOTE = 8'h22;
	localparam logic [7:0] CHR_BSLASH = 8'h5C;
	localparam logic [7:0] CHR_SLASH = 8'h2F;
	localparam logic [7:0] CHR_B = 8'h62;
	localparam logic [7:0] CHR_F = 8'h66;
	localparam logic [7:0] CHR_N = 8'h6E;
	localparam logic [7:0] CHR_R = 8'h72;
	localparam logic [7:0] CHR_T = 8'h74;
	localparam logic [7:0] CHR_U = 8'h75;

	jsu_pkg::phase_t phase_q, phase_d;
	logic [1:0]      hex_q, hex_d;
	logic [15:0]     cp_q, cp_d;
	logic            accept;
	logic            hex_ok;
	logic [3:0]      hex_v;
	logic [15:0]     cp_next;
	jsu_pkg::run_t   run;

	// Decode one hex digit of either case
	always_comb begin
		hex_ok = 1'b1;
		hex_v = 4'd0;
		if (item.in_byte >= 8'h30 && item.in_byte <= 8'h39) begin
			hex_v = 4'(item.in_byte - 8'h30);
		end else if (item.in_byte >= 8'h61 && item.in_byte <= 8'h66) begin
			hex_v = 4'(item.in_byte - 8'h57);
		end else if (item.in_byte >= 8'h41 && item.in_byte <= 8'h46) begin
			hex_v = 4'(item.in_byte - 8'h37);
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign cp_next = {cp_q[11:0], hex_v};
	assign item_stall = queue_full;
	assign accept = item_valid && !queue_full;

	// Next state and run for the accepted byte
	always_comb begin
		phase_d = phase_q;
		hex_d = hex_q;
		cp_d = cp_q;
		run = '0;
		run.kind = jsu_pkg::KIND_BYTE;
		if (accept) begin
			if (item.end_of_data) begin
				if (phase_q != jsu_pkg::PH_WAIT) begin
					phase_d = jsu_pkg::PH_WAIT;
					hex_d = 2'd0;
					cp_d = 16'd0;
					run.count = 2'd1;
					run.kind = jsu_pkg::KIND_ERR;
				end
			end else begin
				unique case (phase_q)
					jsu_pkg::PH_WAIT: begin
						if (item.in_byte == CHR_QUOTE) begin
							phase_d = jsu_pkg::PH_STR;
						end else begin
							run.count = 2'd1;
							run.kind = jsu_pkg::KIND_ERR;
						end
					end
					jsu_pkg::PH_STR: begin
						if (item.in_byte == CHR_QUOTE) begin
							phase_d = jsu_pkg::PH_WAIT;
							run.count = 2'd1;
							run.kind = jsu_pkg::KIND_CLOSE;
						end else if (item.in_byte == CHR_BSLASH) begin
							phase_d = jsu_pkg::PH_ESC;
						end else begin
							run.count = 2'd1;
							run.data[0] = item.in_byte;
						end
					end
					jsu_pkg::PH_ESC: begin
						phase_d = jsu_pkg::PH_STR;
						run.count = 2'd1;
						unique case (item.in_byte)
							CHR_QUOTE:  run.data[0] = CHR_QUOTE;
							CHR_BSLASH: run.data[0] = CHR_BSLASH;
							CHR_SLASH:  run.data[0] = CHR_SLASH;
							CHR_B:      run.data[0] = 8'h08;
							CHR_F:      run.data[0] = 8'h0C;
							CHR_N:      run.data[0] = 8'h0A;
							CHR_R:      run.data[0] = 8'h0D;
							CHR_T:      run.data[0] = 8'h09;
							CHR_U: begin
								phase_d = jsu_pkg::PH_HEX;
								hex_d = 2'd0;
								cp_d = 16'd0;
								run.count = 2'd0;
							end
							default: begin
								phase_d = jsu_pkg::PH_WAIT;
								hex_d = 2'd0;
								cp_d = 16'd0;
								run.kind = jsu_pkg::KIND_ERR;
							end
						endcase
					end
					jsu_pkg::PH_HEX: begin
						if (!hex_ok) begin
							phase_d = jsu_pkg::PH_WAIT;
							hex_d = 2'd0;
							cp_d = 16'd0;
							run.count = 2'd1;
							run.kind = jsu_pkg::KIND_ERR;
						end else if (hex_q == 2'd3) begin
							// Fourth digit: encode the code point as UTF-8
							phase_d = jsu_pkg::PH_STR;
							hex_d = 2'd0;
							cp_d = 16'd0;
							if (cp_next < 16'h0080) begin
								run.count = 2'd1;
								run.data[0] = cp_next[7:0];
							end else if (cp_next < 16'h0800) begin
								run.count = 2'd2;
								run.data[0] = {3'b110, cp_next[10:6]};
								run.data[1] = {2'b10, cp_next[5:0]};
							end else begin
								run.count = 2'd3;
								run.data[0] = {4'b1110, cp_next[15:12]};
								run.data[1] = {2'b10, cp_next[11:6]};
								run.data[2] = {2'b10, cp_next[5:0]};
							end
						end else begin
							hex_d = hex_q + 2'd1;
							cp_d = cp_next;
						end
					end
					default: begin
						phase_d = jsu_pkg::PH_WAIT;
					end
				endcase
			end
		end
	end

	assign push = accept && (run.count != 2'd0);
	assign push_run = run;

	// Hold decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jsu_pkg::PH_WAIT;
			hex_q <= 2'd0;
			cp_q <= 16'd0;
		end else begin
			phase_q <= phase_d;
			hex_q <= hex_d;
			cp_q <= cp_d;
		end
	end

endmodule

// File: src/jsu_queue.sv
module jsu_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  jsu_pkg::run_t  push_run,
	output logic           full,
	input  logic           pop,
	output jsu_pkg::head_t head
);

	jsu_pkg::run_t           mem_q [jsu_pkg::QDepth];
	logic [jsu_pkg::QAw-1:0] wr_ptr_q;
	logic [jsu_pkg::QAw-1:0] rd_ptr_q;
	logic [jsu_pkg::QAw:0]   cnt_q;
	logic                    do_pop;

	assign full = (cnt_q == (jsu_pkg::QAw+1)'(jsu_pkg::QDepth));
	assign head.valid = (cnt_q != '0);
	assign head.run = mem_q[rd_ptr_q];
	assign do_pop = pop && head.valid;

	// Store runs
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_run;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/jsu_back.sv
module jsu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  jsu_pkg::head_t   head,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_stall,
	output jsu_pkg::result_t result
);

	logic [1:0]       idx_q;
	logic             valid_q;
	jsu_pkg::result_t result_q;
	logic             load;
	logic             is_last;

	assign load = head.valid && (!valid_q || !result_stall);
	assign is_last = (idx_q == head.run.count - 2'd1);
	assign pop = load && is_last;

	// Load output register with the next byte of the head run
	always_ff @(posedge clk) begin
		if (load) begin
			result_q.out_byte <= head.run.data[idx_q];
			result_q.kind <= head.run.kind;
			result_q.last_of_run <= is_last;
		end
	end

	// Advance within the run and track output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = valid_q;
	assign result = result_q;

endmodule

// File: src/json_string_unescape_utf8.sv
// Channel  Direction  Handshake                  Payload
// item     in         item_valid / item_stall    jsu_pkg::item_t (in_byte, end_of_data)
// result   out        result_valid / result_stall jsu_pkg::result_t (out_byte, kind, last_of_run)
//
// One input byte is taken per cycle while item_stall is low; the classifier decides all
// of its results in that cycle. Results pass the run queue and leave the output register one
// per cycle unless stalled; a \u escape giving three bytes holds the emitter until all leave.
// A four-entry run queue between classifier and emitter absorbs such bursts; item_stall
// rises only while that queue is full. result_stall holds the output register.
// Reset clears the decoder to waiting for an opening quote and empties the queue.
module json_string_unescape_utf8 (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  jsu_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output jsu_pkg::result_t result
);

	logic           queue_full;
	logic           push;
	jsu_pkg::run_t  push_run;
	logic           pop;
	jsu_pkg::head_t head;

	// Classify input bytes
	jsu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.queue_full (queue_full),
		.push       (push),
		.push_run   (push_run)
	);

	// Buffer runs
	jsu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_run (push_run),
		.full     (queue_full),
		.pop      (pop),
		.head     (head)
	);

	// Emit results
	jsu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// File: src/jsu_checker.sv
module jsu_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input jsu_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_stall,
	input jsu_pkg::result_t result
);

	// Hold a stalled item
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("stalled item changed");

	// Hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// Close and error marks end their run
	a_mark_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.kind == jsu_pkg::KIND_CLOSE ||
			result.kind == jsu_pkg::KIND_ERR) |-> result.last_of_run)
		else $error("close or error mark not last of run");

	// Marks carry a zero byte
	a_mark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != jsu_pkg::KIND_BYTE |-> result.out_byte == 8'd0)
		else $error("mark carries nonzero byte");

	// Kind stays in range
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.kind != 2'd3)
		else $error("undefined result kind");

endmodule

bind json_string_unescape_utf8 jsu_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
